@@ sv/ucal_pkg.sv @@
// Shared constants, payload structs and the month table for the timestamp-to-calendar pipeline.
// Used by every module of the block; depends on nothing else.
package ucal_pkg;

	// Seconds between 1970-01-01 and 2000-01-01.
	localparam logic [31:0] EPOCH_2000_OFFSET = 32'd946684800;

	// Divisors and their truncated reciprocals; each estimate is the quotient or one less.
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [15:0] DAY_RECIP     = 16'd49710;  // floor(2^32 / 86400)
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  HOUR_RECIP    = 6'd36;      // floor(2^17 / 3600)
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [6:0]  MIN_RECIP     = 7'd68;      // floor(2^12 / 60)
	localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
	localparam logic [5:0]  QUAD_RECIP    = 6'd44;      // floor(2^16 / 1461)
	localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
	localparam logic [14:0] WEEK_RECIP    = 15'd18724;  // floor(2^17 / 7)

	// Day-of-quad boundaries where years 1, 2 and 3 of a four-year cycle begin.
	localparam logic [10:0] YEAR1_START = 11'd366;
	localparam logic [10:0] YEAR2_START = 11'd731;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	// Whole days and the second of that day.
	typedef struct packed {
		logic [15:0] days;
		logic [16:0] sod;
	} ucal_day_t;

	// Time-of-day fields.
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
	} ucal_clock_t;

	// Date fields.
	typedef struct packed {
		logic [4:0] day_of_month;
		logic [3:0] month_number;
		logic [7:0] year_offset;
		logic [2:0] weekday;
	} ucal_date_t;

	// Day of the year on which a month starts; the month index counts from 0.
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		// February 29 shifts every later month by one day.
		if (leap && (idx >= 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

@@ sv/unix_time_to_calendar.sv @@
// Top level of the Unix-seconds to calendar converter: handshake, valid chain and stall control.
// Depends on ucal_pkg, ucal_day_split, ucal_clock_split and ucal_date_split.
//
//   channel  direction  handshake             payload
//   ts       in         ts_valid / ts_ready   unix_seconds
//   cal      out        cal_valid / cal_ready second, minute, hour, day_of_month,
//                                             month_number, year_offset, weekday
//
// Ten register stages; an accepted request passes through them in order to the outputs.
// One request is accepted per cycle unless the output stalls; the depth is set by the
// reciprocal multiplications and their correction steps for the day, hour, minute,
// four-year cycle and week divisions.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
module unix_time_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ts_valid,
	output logic        ts_ready,
	input  logic [31:0] unix_seconds,
	output logic        cal_valid,
	input  logic        cal_ready,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_number,
	output logic [7:0]  year_offset,
	output logic [2:0]  weekday
);
	import ucal_pkg::*;

	logic        adv;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	ucal_day_t   day_w;
	ucal_clock_t clock_w;
	ucal_date_t  date_w;

	// The whole pipeline moves whenever the output stage is empty or being taken.
	assign adv      = !valid_s10 || cal_ready;
	assign ts_ready = adv;

	// Valid bits travel alongside the payload stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= ts_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// Seconds to days and second of day.
	ucal_day_split u_day (
		.clk          (clk),
		.adv          (adv),
		.unix_seconds (unix_seconds),
		.day_out      (day_w)
	);

	// Time of day.
	ucal_clock_split u_clock (
		.clk       (clk),
		.adv       (adv),
		.day_in    (day_w),
		.clock_out (clock_w)
	);

	// Calendar date and weekday.
	ucal_date_split u_date (
		.clk      (clk),
		.adv      (adv),
		.day_in   (day_w),
		.date_out (date_w)
	);

	assign cal_valid    = valid_s10;
	assign second       = clock_w.second;
	assign minute       = clock_w.minute;
	assign hour         = clock_w.hour;
	assign day_of_month = date_w.day_of_month;
	assign month_number = date_w.month_number;
	assign year_offset  = date_w.year_offset;
	assign weekday      = date_w.weekday;

`ifndef SYNTHESIS
	// An accepted request enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts_ready |=> valid_s1)
		else $error("accepted request did not reach stage one");

	// A stall freezes the inner valid chain.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5,
			valid_s6, valid_s7, valid_s8, valid_s9}))
		else $error("pipeline moved during a stall");

	// Time fields of a delivered result are in range.
	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
		else $error("time of day out of range");

	// Date fields of a delivered result are in range.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (month_number >= 4'd1) && (month_number <= 4'd12)
			&& (day_of_month >= 5'd1) && (weekday < 3'd7) && (year_offset <= 8'd136))
		else $error("calendar date out of range");
`endif

endmodule

@@ sv/ucal_day_split.sv @@
// Stages 1 to 4: removes the 2000 epoch offset and splits seconds into days and second of day.
// Depends on ucal_pkg for the offset, the divisor and its reciprocal.
module ucal_day_split (
	input  logic              clk,
	input  logic              adv,
	input  logic [31:0]       unix_seconds,
	output ucal_pkg::ucal_day_t day_out
);
	import ucal_pkg::*;

	logic [31:0] t_s1;
	logic [31:0] t_s2;
	logic [15:0] q_s2;
	logic [15:0] q_s3;
	logic [17:0] r_s3;
	ucal_day_t   day_s4;

	logic [47:0] day_prod;
	logic [31:0] day_back;
	logic [31:0] r_full;

	// Quotient estimate by reciprocal multiplication.
	assign day_prod = 48'(t_s1) * 48'(DAY_RECIP);

	// Raw remainder; below twice the divisor because the estimate is at most one short.
	assign day_back = 32'(q_s2) * 32'(SECS_PER_DAY);
	assign r_full   = t_s2 - day_back;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= unix_seconds - EPOCH_2000_OFFSET;
			t_s2 <= t_s1;
			q_s2 <= day_prod[47:32];
			q_s3 <= q_s2;
			r_s3 <= r_full[17:0];
			// One correction step finishes the division.
			if (r_s3 >= 18'(SECS_PER_DAY)) begin
				day_s4.days <= q_s3 + 16'd1;
				day_s4.sod  <= 17'(r_s3 - 18'(SECS_PER_DAY));
			end else begin
				day_s4.days <= q_s3;
				day_s4.sod  <= r_s3[16:0];
			end
		end
	end

	assign day_out = day_s4;

endmodule

@@ sv/ucal_clock_split.sv @@
// Stages 5 to 10: splits the second of the day into hour, minute and second.
// Depends on ucal_pkg for the divisors, reciprocals and payload structs.
module ucal_clock_split (
	input  logic                  clk,
	input  logic                  adv,
	input  ucal_pkg::ucal_day_t   day_in,
	output ucal_pkg::ucal_clock_t clock_out
);
	import ucal_pkg::*;

	logic [16:0] sod_s5;
	logic [4:0]  hr_s5;
	logic [4:0]  hr_s6;
	logic [12:0] soh_s6;
	logic [4:0]  hr_s7;
	logic [11:0] soh_s7;
	logic [4:0]  hr_s8;
	logic [11:0] soh_s8;
	logic [5:0]  min_s8;
	logic [4:0]  hr_s9;
	logic [5:0]  min_s9;
	logic [6:0]  sec_s9;
	ucal_clock_t clock_s10;

	logic [21:0] hr_prod;
	logic [16:0] soh_full;
	logic [17:0] min_prod;
	logic [11:0] sec_full;

	// Hour estimate and raw second of the hour.
	assign hr_prod  = 22'(day_in.sod) * 22'(HOUR_RECIP);
	assign soh_full = sod_s5 - (17'(hr_s5) * 17'(SECS_PER_HOUR));

	// Minute estimate and raw second of the minute.
	assign min_prod = 18'(soh_s7) * 18'(MIN_RECIP);
	assign sec_full = soh_s8 - (12'(min_s8) * 12'(SECS_PER_MIN));

	always_ff @(posedge clk) begin
		if (adv) begin
			sod_s5 <= day_in.sod;
			hr_s5  <= hr_prod[21:17];
			hr_s6  <= hr_s5;
			soh_s6 <= soh_full[12:0];
			// Correct the hour quotient.
			if (soh_s6 >= 13'(SECS_PER_HOUR)) begin
				hr_s7  <= hr_s6 + 5'd1;
				soh_s7 <= 12'(soh_s6 - 13'(SECS_PER_HOUR));
			end else begin
				hr_s7  <= hr_s6;
				soh_s7 <= soh_s6[11:0];
			end
			hr_s8  <= hr_s7;
			soh_s8 <= soh_s7;
			min_s8 <= min_prod[17:12];
			hr_s9  <= hr_s8;
			min_s9 <= min_s8;
			sec_s9 <= sec_full[6:0];
			// Correct the minute quotient.
			clock_s10.hour <= hr_s9;
			if (sec_s9 >= 7'(SECS_PER_MIN)) begin
				clock_s10.minute <= min_s9 + 6'd1;
				clock_s10.second <= 6'(sec_s9 - 7'(SECS_PER_MIN));
			end else begin
				clock_s10.minute <= min_s9;
				clock_s10.second <= sec_s9[5:0];
			end
		end
	end

	assign clock_out = clock_s10;

endmodule

@@ sv/ucal_date_split.sv @@
// Stages 5 to 10: turns the day count into year, month, day of month and weekday.
// Depends on ucal_pkg for the divisors, year boundaries, month table and payload structs.
module ucal_date_split (
	input  logic                 clk,
	input  logic                 adv,
	input  ucal_pkg::ucal_day_t  day_in,
	output ucal_pkg::ucal_date_t date_out
);
	import ucal_pkg::*;

	logic [15:0] days_s5;
	logic [5:0]  quad_s5;
	logic [12:0] wq_s5;
	logic [5:0]  quad_s6;
	logic [11:0] doq_s6;
	logic [3:0]  wr_s6;
	logic [5:0]  quad_s7;
	logic [10:0] doq_s7;
	logic [2:0]  wr_s7;
	logic [7:0]  year_s8;
	logic [8:0]  doy_s8;
	logic        leap_s8;
	logic [2:0]  wd_s8;
	logic [7:0]  year_s9;
	logic [8:0]  doy_s9;
	logic        leap_s9;
	logic [2:0]  wd_s9;
	logic [3:0]  mon_s9;
	ucal_date_t  date_s10;

	logic [21:0] quad_prod;
	logic [29:0] wq_prod;
	logic [15:0] doq_full;
	logic [15:0] wr_full;
	logic [1:0]  yiq;
	logic [10:0] doy_full;
	logic [3:0]  mon_idx;
	logic [8:0]  day_full;

	// Quotient estimates for the four-year cycle and the week.
	assign quad_prod = 22'(day_in.days) * 22'(QUAD_RECIP);
	assign wq_prod   = 30'(day_in.days) * 30'(WEEK_RECIP);

	// Raw remainders, each below twice its divisor.
	assign doq_full = days_s5 - (16'(quad_s5) * 16'(DAYS_PER_QUAD));
	assign wr_full  = days_s5 - (16'(wq_s5) * 16'(DAYS_PER_WEEK));

	// Year within the cycle; only the first year of a cycle is a leap year.
	always_comb begin
		if (doq_s7 < YEAR1_START) begin
			yiq      = 2'd0;
			doy_full = doq_s7;
		end else if (doq_s7 < YEAR2_START) begin
			yiq      = 2'd1;
			doy_full = doq_s7 - YEAR1_START;
		end else if (doq_s7 < YEAR3_START) begin
			yiq      = 2'd2;
			doy_full = doq_s7 - YEAR2_START;
		end else begin
			yiq      = 2'd3;
			doy_full = doq_s7 - YEAR3_START;
		end
	end

	// Month index: the last month whose first day is not after the day of the year.
	always_comb begin
		mon_idx = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s8 >= month_start(leap_s8, 4'(k))) begin
				mon_idx = 4'(k);
			end
		end
	end

	assign day_full = doy_s9 - month_start(leap_s9, mon_s9) + 9'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			days_s5 <= day_in.days;
			quad_s5 <= quad_prod[21:16];
			wq_s5   <= wq_prod[29:17];
			quad_s6 <= quad_s5;
			doq_s6  <= doq_full[11:0];
			wr_s6   <= wr_full[3:0];
			// Correct both quotients.
			if (doq_s6 >= 12'(DAYS_PER_QUAD)) begin
				quad_s7 <= quad_s6 + 6'd1;
				doq_s7  <= 11'(doq_s6 - 12'(DAYS_PER_QUAD));
			end else begin
				quad_s7 <= quad_s6;
				doq_s7  <= doq_s6[10:0];
			end
			if (wr_s6 >= 4'(DAYS_PER_WEEK)) begin
				wr_s7 <= 3'(wr_s6 - 4'(DAYS_PER_WEEK));
			end else begin
				wr_s7 <= wr_s6[2:0];
			end
			year_s8 <= {quad_s7, 2'b00} + {6'd0, yiq};
			doy_s8  <= doy_full[8:0];
			leap_s8 <= (yiq == 2'd0);
			// 2000-01-01 was a Saturday, so the weekday is the day remainder plus six.
			wd_s8   <= (wr_s7 == 3'd0) ? 3'd6 : (wr_s7 - 3'd1);
			year_s9 <= year_s8;
			doy_s9  <= doy_s8;
			leap_s9 <= leap_s8;
			wd_s9   <= wd_s8;
			mon_s9  <= mon_idx;
			date_s10.day_of_month <= day_full[4:0];
			date_s10.month_number <= mon_s9 + 4'd1;
			date_s10.year_offset  <= year_s9;
			date_s10.weekday      <= wd_s9;
		end
	end

	assign date_out = date_s10;

endmodule
